>>> src/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Types, coefficients and helper functions shared by the YUYV to RGB565
// conversion pipeline.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int SUM_W = 20;
  localparam int PROD_W = 18;

  localparam logic signed [7:0] V_OFFSET_RESET = 8'sd18;

  localparam logic signed [9:0] LUMA_BIAS = 10'sd16;
  localparam logic signed [9:0] CHROMA_BIAS = 10'sd128;

  localparam logic signed [PROD_W-1:0] K_Y = 18'sd298;
  localparam logic signed [SUM_W-1:0] K_RV = 20'sd409;
  localparam logic signed [SUM_W-1:0] K_GU = 20'sd100;
  localparam logic signed [SUM_W-1:0] K_GV = 20'sd208;
  localparam logic signed [SUM_W-1:0] K_BU = 20'sd516;
  localparam logic signed [SUM_W-1:0] ROUND = 20'sd128;

  // bias-removed samples after the offset stage
  typedef struct packed {
    logic signed [8:0] c0;
    logic signed [8:0] c1;
    logic signed [8:0] d;
    logic signed [9:0] e;
  } prep_t;

  // luma products and per-channel chroma terms, rounding folded in
  typedef struct packed {
    logic signed [PROD_W-1:0] c0;
    logic signed [PROD_W-1:0] c1;
    logic signed [SUM_W-1:0] rt;
    logic signed [SUM_W-1:0] gt;
    logic signed [SUM_W-1:0] bt;
  } mult_t;

  // channel sums before the shift and clip
  typedef struct packed {
    logic signed [SUM_W-1:0] r0;
    logic signed [SUM_W-1:0] g0;
    logic signed [SUM_W-1:0] b0;
    logic signed [SUM_W-1:0] r1;
    logic signed [SUM_W-1:0] g1;
    logic signed [SUM_W-1:0] b1;
  } sum_t;

  // shift by 8 and saturate to 0..255
  function automatic logic [7:0] clip_channel(input logic signed [SUM_W-1:0] s);
    if (s[SUM_W-1]) begin
      return 8'h00;
    end else if (|s[SUM_W-2:16]) begin
      return 8'hFF;
    end else begin
      return s[15:8];
    end
  endfunction

  function automatic logic [15:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

>>> src/y2r_prep.sv
// ----------------------------------------------------------------------------
// y2r_prep
// First stage: removes luma and chroma bias and applies the V offset.
// ----------------------------------------------------------------------------
module y2r_prep (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              luma_first,
  input  logic [7:0]              chroma_u,
  input  logic [7:0]              luma_second,
  input  logic [7:0]              chroma_v,
  input  logic signed [7:0]       v_offset,
  output logic                    out_valid,
  input  logic                    out_ready,
  output y2r_pkg::prep_t          out_data
);
  import y2r_pkg::*;

  prep_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.c0 = 9'($signed({2'b00, luma_first}) - LUMA_BIAS);
    data_next.c1 = 9'($signed({2'b00, luma_second}) - LUMA_BIAS);
    data_next.d  = 9'($signed({2'b00, chroma_u}) - CHROMA_BIAS);
    // v minus offset may leave 0..255, kept unclipped
    data_next.e  = $signed({2'b00, chroma_v}) - 10'(v_offset) - CHROMA_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> src/y2r_mult.sv
// ----------------------------------------------------------------------------
// y2r_mult
// Second stage: constant multiplications for luma and chroma terms.
// ----------------------------------------------------------------------------
module y2r_mult (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  y2r_pkg::prep_t          in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output y2r_pkg::mult_t          out_data
);
  import y2r_pkg::*;

  mult_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.c0 = PROD_W'(in_data.c0) * K_Y;
    data_next.c1 = PROD_W'(in_data.c1) * K_Y;
    data_next.rt = SUM_W'(in_data.e) * K_RV + ROUND;
    data_next.gt = ROUND - SUM_W'(in_data.d) * K_GU - SUM_W'(in_data.e) * K_GV;
    data_next.bt = SUM_W'(in_data.d) * K_BU + ROUND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> src/y2r_sum.sv
// ----------------------------------------------------------------------------
// y2r_sum
// Third stage: adds the luma product to each chroma term for both pixels.
// ----------------------------------------------------------------------------
module y2r_sum (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  y2r_pkg::mult_t          in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output y2r_pkg::sum_t           out_data
);
  import y2r_pkg::*;

  sum_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.r0 = SUM_W'(in_data.c0) + in_data.rt;
    data_next.g0 = SUM_W'(in_data.c0) + in_data.gt;
    data_next.b0 = SUM_W'(in_data.c0) + in_data.bt;
    data_next.r1 = SUM_W'(in_data.c1) + in_data.rt;
    data_next.g1 = SUM_W'(in_data.c1) + in_data.gt;
    data_next.b1 = SUM_W'(in_data.c1) + in_data.bt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> src/y2r_pack.sv
// ----------------------------------------------------------------------------
// y2r_pack
// Last stage: clips each channel and packs the two RGB565 words.
// ----------------------------------------------------------------------------
module y2r_pack (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  y2r_pkg::sum_t           in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             pixel_first,
  output logic [15:0]             pixel_second
);
  import y2r_pkg::*;

  logic [15:0] first_next;
  logic [15:0] second_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    first_next  = pack_pixel(clip_channel(in_data.r0), clip_channel(in_data.g0),
                             clip_channel(in_data.b0));
    second_next = pack_pixel(clip_channel(in_data.r1), clip_channel(in_data.g1),
                             clip_channel(in_data.b1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pixel_first  <= first_next;
      pixel_second <= second_next;
    end
  end

endmodule

>>> src/yuyv_to_rgb565_pair.sv
// each word is registered in prep, mult, sum and pack; out_stall can hold it there
// throughput: one pair per cycle unless out_stall, four-stage valid/stall pipeline
// each stage fills a bubble on its own, so in_stall rises only when all are full
// reset (rst, synchronous): clears every stage valid and loads v_offset with 18
// ----------------------------------------------------------------------------
// yuyv_to_rgb565_pair
// Converts one packed YUYV pair into two RGB565 pixels with BT.601 integer math.
// ----------------------------------------------------------------------------
module yuyv_to_rgb565_pair (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        luma_first,
  input  logic [7:0]        chroma_u,
  input  logic [7:0]        luma_second,
  input  logic [7:0]        chroma_v,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       pixel_first,
  output logic [15:0]       pixel_second,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic signed [7:0] cfg_data
);
  import y2r_pkg::*;

  logic signed [7:0] v_offset;

  logic  prep_in_ready;
  logic  prep_valid;
  logic  mult_in_ready;
  logic  mult_valid;
  logic  sum_in_ready;
  logic  sum_valid;
  logic  pack_in_ready;
  prep_t prep_data;
  mult_t mult_data;
  sum_t  sum_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = !prep_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_offset <= V_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      v_offset <= cfg_data;
    end
  end

  y2r_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (prep_in_ready),
    .luma_first  (luma_first),
    .chroma_u    (chroma_u),
    .luma_second (luma_second),
    .chroma_v    (chroma_v),
    .v_offset    (v_offset),
    .out_valid   (prep_valid),
    .out_ready   (mult_in_ready),
    .out_data    (prep_data)
  );

  y2r_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (mult_in_ready),
    .in_data   (prep_data),
    .out_valid (mult_valid),
    .out_ready (sum_in_ready),
    .out_data  (mult_data)
  );

  y2r_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mult_valid),
    .in_ready  (sum_in_ready),
    .in_data   (mult_data),
    .out_valid (sum_valid),
    .out_ready (pack_in_ready),
    .out_data  (sum_data)
  );

  y2r_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sum_valid),
    .in_ready     (pack_in_ready),
    .in_data      (sum_data),
    .out_valid    (out_valid),
    .out_ready    (!out_stall),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second)
  );

`ifndef SYNTHESIS
  // back-pressure reaches the input only with every stage occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (prep_valid && mult_valid && sum_valid && out_valid && out_stall))
    else $error("input stalled while a pipeline stage holds a bubble");

  // offset register moves only on a config word
  a_offset_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_valid) |-> $stable(v_offset))
    else $error("v_offset changed without a config write");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!prep_valid && !mult_valid && !sum_valid && !out_valid))
    else $error("pipeline holds a word right after reset");
`endif

endmodule

>>> verif/yuyv_to_rgb565_pair_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb565_pair_test
// Drives YUYV pairs through the converter under several v_offset settings and
// idle/stall mixes, and checks each RGB565 word against a local BT.601 model or typed row.
// ----------------------------------------------------------------------------
module yuyv_to_rgb565_pair_test;
  import y2r_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES = 6;
  localparam int PAIRS_PER_PHASE = 100;
  localparam int DIR_ROWS = 20;

  typedef struct packed {
    logic [7:0]  y0;
    logic [7:0]  u;
    logic [7:0]  y1;
    logic [7:0]  v;
    logic        typed;
    logic [15:0] px0;
    logic [15:0] px1;
  } pair_row_t;

  typedef struct packed {
    logic [15:0] first_px;
    logic [15:0] second_px;
  } pixel_pair_t;

  // v = 146 gives neutral chroma at the reset offset, so only luma matters
  localparam pair_row_t PAIR_ROWS [DIR_ROWS] = '{
    '{8'd255, 8'd128, 8'd0,   8'd146, 1'b1, 16'hFFFF, 16'h0000},
    '{8'd16,  8'd128, 8'd235, 8'd146, 1'b1, 16'h0000, 16'hFFFF},
    '{8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 16'h0000, 16'h0000},
    '{8'd255, 8'd255, 8'd0,   8'd255, 1'b0, 16'h0000, 16'h0000},
    '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 16'h0000, 16'h0000},
    '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 16'h0000, 16'h0000},
    '{8'd128, 8'd128, 8'd128, 8'd128, 1'b0, 16'h0000, 16'h0000},
    '{8'd128, 8'd128, 8'd64,  8'd146, 1'b0, 16'h0000, 16'h0000},
    '{8'hAA,  8'h55,  8'h55,  8'hAA,  1'b0, 16'h0000, 16'h0000},
    '{8'h55,  8'hAA,  8'hAA,  8'h55,  1'b0, 16'h0000, 16'h0000},
    '{8'h01,  8'h02,  8'h04,  8'h08,  1'b0, 16'h0000, 16'h0000},
    '{8'h10,  8'h20,  8'h40,  8'h80,  1'b0, 16'h0000, 16'h0000},
    '{8'hFE,  8'hFD,  8'hFB,  8'hF7,  1'b0, 16'h0000, 16'h0000},
    '{8'hEF,  8'hDF,  8'hBF,  8'h7F,  1'b0, 16'h0000, 16'h0000},
    '{8'd235, 8'd16,  8'd16,  8'd240, 1'b0, 16'h0000, 16'h0000},
    '{8'd235, 8'd240, 8'd16,  8'd16,  1'b0, 16'h0000, 16'h0000},
    '{8'd81,  8'd90,  8'd145, 8'd240, 1'b0, 16'h0000, 16'h0000},
    '{8'd41,  8'd240, 8'd210, 8'd110, 1'b0, 16'h0000, 16'h0000},
    '{8'd17,  8'd127, 8'd15,  8'd18,  1'b0, 16'h0000, 16'h0000},
    '{8'd200, 8'd129, 8'd100, 8'd19,  1'b0, 16'h0000, 16'h0000}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        luma_first = '0;
  logic [7:0]        chroma_u = '0;
  logic [7:0]        luma_second = '0;
  logic [7:0]        chroma_v = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [15:0]       pixel_first;
  logic [15:0]       pixel_second;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic signed [7:0] cfg_data = '0;

  logic signed [7:0] offset_now = V_OFFSET_RESET;
  pixel_pair_t       pending_px [$];
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                cycle_count = 0;
  int                error_count = 0;
  int                pairs_sent = 0;
  int                words_checked = 0;

  yuyv_to_rgb565_pair DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .luma_first   (luma_first),
    .chroma_u     (chroma_u),
    .luma_second  (luma_second),
    .chroma_v     (chroma_v),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // floor-shift by 8 then saturate; negative sums never reach the shift
  function automatic logic [7:0] saturate_channel(input int acc);
    if (acc < 0) begin
      return 8'h00;
    end
    if ((acc >> 8) > 255) begin
      return 8'hFF;
    end
    return 8'(acc >> 8);
  endfunction

  function automatic logic [15:0] bt601_rgb565(input logic [7:0] y, input int d, input int e);
    int         luma_term;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    luma_term = 298 * (int'(y) - 16);
    red = saturate_channel(luma_term + 409 * e + 128);
    green = saturate_channel(luma_term - 100 * d - 208 * e + 128);
    blue = saturate_channel(luma_term + 516 * d + 128);
    return (16'(red & 8'hF8) << 8) | (16'(green & 8'hFC) << 3) | 16'(blue >> 3);
  endfunction

  function automatic pixel_pair_t convert_pair(input logic [7:0] y0, input logic [7:0] u,
                                               input logic [7:0] y1, input logic [7:0] v);
    pixel_pair_t px;
    int          d;
    int          e;
    d = int'(u) - 128;
    // shifted v is used unclipped, it may leave 0..255
    e = int'(v) - int'(offset_now) - 128;
    px.first_px = bt601_rgb565(y0, d, e);
    px.second_px = bt601_rgb565(y1, d, e);
    return px;
  endfunction

  // bias toward the clip points of the luma and chroma ranges and mid-scale 128
  function automatic logic [7:0] pick_sample();
    unique case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd235;
      4: return 8'd128;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // returns on the edge that takes the word; valid is left high for the next caller
  task automatic send_pair(input logic [7:0] y0, input logic [7:0] u, input logic [7:0] y1,
                           input logic [7:0] v, input logic typed, input logic [15:0] px0,
                           input logic [15:0] px1);
    pixel_pair_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    luma_first <= y0;
    chroma_u <= u;
    luma_second <= y1;
    chroma_v <= v;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    want = typed ? pixel_pair_t'({px0, px1}) : convert_pair(y0, u, y1, v);
    pending_px.push_back(want);
    pairs_sent++;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_offset(input logic signed [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    offset_now = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("yuyv_to_rgb565_pair: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_pair_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_px.size() == 0) begin
          $error("unexpected word: pixel_first %h pixel_second %h", pixel_first, pixel_second);
          error_count++;
        end else begin
          want = pending_px.pop_front();
          words_checked++;
          if (pixel_first !== want.first_px) begin
            $error("pixel_first: expected %h, got %h", want.first_px, pixel_first);
            error_count++;
          end
          if (pixel_second !== want.second_px) begin
            $error("pixel_second: expected %h, got %h", want.second_px, pixel_second);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    logic signed [7:0] phase_offset [PHASES];
    int                send_mix [4];
    int                recv_mix [4];
    phase_offset = '{-8'sd128, 8'sd127, 8'sd0, 8'sd0, -8'sd1, V_OFFSET_RESET};
    phase_offset[3] = 8'($urandom_range(255));
    send_mix = '{0, 61, 0, 14};
    recv_mix = '{0, 0, 61, 14};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run at the reset offset, which also checks its value
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_pair(PAIR_ROWS[i].y0, PAIR_ROWS[i].u, PAIR_ROWS[i].y1, PAIR_ROWS[i].v,
                PAIR_ROWS[i].typed, PAIR_ROWS[i].px0, PAIR_ROWS[i].px1);
    end
    drain_pipe();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_offset(phase_offset[p]);
      send_idle_pct = send_mix[p % 4];
      recv_stall_pct = recv_mix[p % 4];
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                  1'b0, 16'h0000, 16'h0000);
      end
      drain_pipe();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d yuyv pairs, checked %0d words over %0d offset settings",
             pairs_sent, words_checked, PHASES + 1);
    $display("idle mixes: none, sender gaps, receiver stalls, both; %0d cycles", cycle_count);
    if (error_count == 0) begin
      $display("yuyv_to_rgb565_pair: match");
    end else begin
      $display("yuyv_to_rgb565_pair: mismatch");
    end
    $finish;
  end

endmodule

>>> yuyv_to_rgb565_pair.f
src/y2r_pkg.sv
src/y2r_prep.sv
src/y2r_mult.sv
src/y2r_sum.sv
src/y2r_pack.sv
src/yuyv_to_rgb565_pair.sv
verif/yuyv_to_rgb565_pair_test.sv
